// File: src/mvcs_pkg.sv
package mvcs_pkg;

	localparam int FRAC_BITS = 16;
	localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
	localparam longint unsigned MASK_Q = ONE_Q - 64'd1;

	// Widths of the fixed point values in the pipeline.
	localparam int LOGW = FRAC_BITS + 3;
	localparam int GAMW = FRAC_BITS + 3;
	localparam int PW = LOGW + GAMW - FRAC_BITS + 1;
	localparam int IPW = PW - FRAC_BITS;
	localparam int YW = FRAC_BITS + 1;
	localparam int IP_MAX = 8;
	localparam int SW = YW + IP_MAX;
	localparam int PRODW = SW + 7;
	localparam int SCW = PRODW - FRAC_BITS + 1;

	localparam int CURVE_LIM = 100;
	localparam int GAM_N = 2 * CURVE_LIM + 1;

	localparam logic [3:0] NOTE_ON = 4'h9;
	localparam logic [1:0] LEN_FULL = 2'd3;
	localparam logic [6:0] VEL_MAX = 7'd127;

	// Exact division by 126 for the linear map: reciprocal plus one correction.
	localparam int BYP_DIV = 126;
	localparam int BYP_BIAS = 63;
	localparam int BYP_RECIP = 1040;
	localparam int BYP_SHIFT = 17;

	typedef enum logic [1:0] {
		REG_FLOOR = 2'd0,
		REG_CEIL  = 2'd1,
		REG_CURVE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [1:0] message_length;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_status;
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [1:0] out_length;
	} res_t;

	typedef struct packed {
		res_t                   msg;
		logic                   note;
		logic                   byp;
		logic                   mzero;
		logic [6:0]             lo;
		logic [6:0]             d;
		logic [14:0]            x;
		logic [8:0]             q0;
		logic [9:0]             sc_byp;
		logic [LOGW-1:0]        lm;
		logic                   neg;
		logic [GAMW-1:0]        gam;
		logic [PW-1:0]          pm;
		logic signed [IPW-1:0]  ip;
		logic [FRAC_BITS-1:0]   f;
		logic [YW-1:0]          y;
		logic [SW-1:0]          s;
	} pipe_t;

	typedef logic [LOGW-1:0] log_tab_t [256];
	typedef logic [GAMW-1:0] gam_tab_t [GAM_N];
	typedef logic [YW-1:0] root_tab_t [FRAC_BITS];

	function automatic longint unsigned isqrt_u64(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		longint unsigned xv;
		res = 0;
		b = 64'd1 << 62;
		xv = x;
		while (b > xv) b = b >> 2;
		while (b != 0) begin
			if (xv >= res + b) begin
				xv = xv - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned log2_int(input int unsigned m);
		int unsigned k;
		longint unsigned xv;
		longint unsigned frac;
		k = 0;
		frac = 0;
		while (k < 31 && (m >> (k + 1)) != 0) k++;
		xv = (longint'(m) << FRAC_BITS) >> k;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			xv = (xv * xv) >> FRAC_BITS;
			if (xv >= 2 * ONE_Q) begin
				xv = xv >> 1;
				frac = frac | (64'd1 << (FRAC_BITS - i));
			end
		end
		return (longint'(k) << FRAC_BITS) | frac;
	endfunction

	function automatic longint unsigned exp2_q(input longint p);
		longint ip;
		longint unsigned f;
		longint unsigned r;
		longint unsigned y;
		ip = p >>> FRAC_BITS;
		f = longint'(p) & MASK_Q;
		r = 2 * ONE_Q;
		y = ONE_Q;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			r = isqrt_u64(r << FRAC_BITS);
			if (((f >> (FRAC_BITS - i)) & 64'd1) != 0) y = (y * r) >> FRAC_BITS;
		end
		if (ip > IP_MAX) ip = IP_MAX;
		if (ip >= 0) return y << ip;
		if (ip <= -63) return 0;
		return y >> (-ip);
	endfunction

	function automatic log_tab_t log2_table();
		log_tab_t t;
		longint unsigned v;
		for (int m = 0; m < 256; m++) begin
			v = (m == 0) ? 64'd0 : log2_int(m);
			t[m] = v[LOGW-1:0];
		end
		return t;
	endfunction

	function automatic gam_tab_t gam_table();
		gam_tab_t t;
		longint c;
		longint unsigned mag;
		longint unsigned v;
		for (int j = 0; j < GAM_N; j++) begin
			c = j - CURVE_LIM;
			mag = (((c < 0) ? -c : c) * ONE_Q + 25) / 50;
			v = exp2_q((c > 0) ? -longint'(mag) : longint'(mag));
			t[j] = v[GAMW-1:0];
		end
		return t;
	endfunction

	function automatic root_tab_t root_table();
		root_tab_t t;
		longint unsigned r;
		r = 2 * ONE_Q;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = isqrt_u64(r << FRAC_BITS);
			t[i] = r[YW-1:0];
		end
		return t;
	endfunction

	localparam log_tab_t LOG2_TAB = log2_table();
	localparam gam_tab_t GAM_TAB = gam_table();
	localparam root_tab_t ROOT_TAB = root_table();
	localparam logic [LOGW-1:0] LOG2_126 = LOG2_TAB[BYP_DIV];

	function automatic logic [7:0] clamp_vel(input logic [SCW-1:0] v);
		logic [7:0] r;
		if (v < SCW'(1)) r = 8'd1;
		else if (v > SCW'(VEL_MAX)) r = {1'b0, VEL_MAX};
		else r = v[7:0];
		return r;
	endfunction

endpackage

// File: src/mvcs_exp2.sv
module mvcs_exp2 (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  mvcs_pkg::pipe_t in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output mvcs_pkg::pipe_t out_data
);

	localparam int N = mvcs_pkg::FRAC_BITS;

	logic            v_sn [N];
	mvcs_pkg::pipe_t p_sn [N];
	logic            rdy [N+1];

	assign rdy[N] = !out_stall;

	// Stage k multiplies by the root 2^(2^-(k+1)) when that fraction bit is set.
	for (genvar k = 0; k < N; k++) begin : g_step
		mvcs_pkg::pipe_t prev;
		mvcs_pkg::pipe_t nxt;
		logic            prev_v;
		logic [2*mvcs_pkg::YW-1:0] prod;

		if (k == 0) begin : g_first
			assign prev = in_data;
			assign prev_v = in_valid;
		end else begin : g_next
			assign prev = p_sn[k-1];
			assign prev_v = v_sn[k-1];
		end

		assign rdy[k] = !v_sn[k] || rdy[k+1];

		always_comb begin
			prod = {{mvcs_pkg::YW{1'b0}}, prev.y} *
				{{mvcs_pkg::YW{1'b0}}, mvcs_pkg::ROOT_TAB[k]};
			nxt = prev;
			if (prev.f[N-1-k]) nxt.y = prod[mvcs_pkg::FRAC_BITS +: mvcs_pkg::YW];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_sn[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_v) begin
				p_sn[k] <= nxt;
			end
		end
	end

	assign in_stall = !rdy[0];
	assign out_valid = v_sn[N-1];
	assign out_data = p_sn[N-1];

endmodule

// File: src/midi_velocity_curve_scaler.sv
// MIDI velocity curve scaler.
// Requests arrive on msg (valid/stall) as one MIDI message each; results leave
// on res (valid/stall), one per request, in order. A request with length 0 is
// taken and dropped without a result. Note-on requests with full length and a
// nonzero velocity get their velocity reshaped by the power curve and mapped
// into the floor..ceiling range; everything else passes through with bytes
// beyond the length read as zero.
// An accepted request passes three setup stages (range, log lookup, exponent
// product), sixteen stages of the exp2 multiply chain, one for the final shift
// and one for the range map and clamp before res_valid. The pipeline takes one
// request per cycle unless stalled; the rate is set by the single multiplier
// in each stage of that chain. The three registers sit on an APB port at byte
// addresses 0, 4 and 8: velocity floor, velocity ceiling and curve amount. The
// user must see that they are written only while the block is idle; the block
// itself does not enforce this. Reset empties the pipeline and loads floor 1,
// ceiling 127 and curve 0. When res_stall is high the pipeline holds; empty
// stages still fill, and msg_stall rises once no stage has room.
module midi_velocity_curve_scaler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  mvcs_pkg::msg_t msg,
	output logic           res_valid,
	input  logic           res_stall,
	output mvcs_pkg::res_t res
);

	localparam int F = mvcs_pkg::FRAC_BITS;

	logic [6:0] floor_q;
	logic [6:0] ceil_q;
	logic [7:0] curve_q;

	mvcs_pkg::reg_idx_t reg_idx;

	assign pready = 1'b1;
	assign reg_idx = mvcs_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 7'd1;
			ceil_q <= mvcs_pkg::VEL_MAX;
			curve_q <= 8'd0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				mvcs_pkg::REG_FLOOR: floor_q <= pwdata[6:0];
				mvcs_pkg::REG_CEIL:  ceil_q <= pwdata[6:0];
				mvcs_pkg::REG_CURVE: curve_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mvcs_pkg::REG_FLOOR: prdata = {25'd0, floor_q};
			mvcs_pkg::REG_CEIL:  prdata = {25'd0, ceil_q};
			mvcs_pkg::REG_CURVE: prdata = {24'd0, curve_q};
			default:             prdata = 32'd0;
		endcase
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	mvcs_pkg::pipe_t p_s1, p_s2, p_s3, p_s4;
	mvcs_pkg::res_t  r_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic exp_in_stall;
	logic exp_out_valid;
	mvcs_pkg::pipe_t exp_out;

	assign rdy5 = !v_s5 || !res_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || !exp_in_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign msg_stall = !rdy1;

	// Stage 1: range, curve table, log lookup, bypass numerator.
	mvcs_pkg::pipe_t     n1;
	logic [6:0]          lo1, hi1;
	logic [7:0]          m1;
	logic signed [7:0]   csat;
	logic [7:0]          gidx;
	logic [mvcs_pkg::LOGW-1:0] la1;

	always_comb begin
		n1 = '0;
		if (floor_q > ceil_q) begin
			lo1 = ceil_q;
			hi1 = floor_q;
		end else begin
			lo1 = floor_q;
			hi1 = ceil_q;
		end
		m1 = msg.second_data - 8'd1;
		if ($signed(curve_q) < -8'sd100) csat = -8'sd100;
		else if ($signed(curve_q) > 8'sd100) csat = 8'sd100;
		else csat = $signed(curve_q);
		gidx = 8'(csat + 8'sd100);
		la1 = mvcs_pkg::LOG2_TAB[m1];

		n1.msg.out_status = msg.status_byte;
		n1.msg.out_first = (msg.message_length > 2'd1) ? msg.first_data : 8'd0;
		n1.msg.out_second = (msg.message_length > 2'd2) ? msg.second_data : 8'd0;
		n1.msg.out_length = msg.message_length;
		n1.note = (msg.status_byte[7:4] == mvcs_pkg::NOTE_ON) &&
			(msg.message_length == mvcs_pkg::LEN_FULL) && (msg.second_data != 8'd0);
		n1.byp = (csat == 8'sd0);
		n1.mzero = (m1 == 8'd0);
		n1.lo = lo1;
		n1.d = hi1 - lo1;
		n1.x = 15'({7'd0, m1} * {8'd0, hi1 - lo1}) + 15'(mvcs_pkg::BYP_BIAS);
		n1.neg = la1 < mvcs_pkg::LOG2_126;
		n1.lm = n1.neg ? (mvcs_pkg::LOG2_126 - la1) : (la1 - mvcs_pkg::LOG2_126);
		n1.gam = mvcs_pkg::GAM_TAB[gidx];
	end

	// Stage 2: exponent magnitude and bypass quotient estimate.
	mvcs_pkg::pipe_t n2;
	logic [mvcs_pkg::LOGW+mvcs_pkg::GAMW-1:0] pprod;
	logic [25:0] qprod;

	always_comb begin
		n2 = p_s1;
		pprod = {{mvcs_pkg::GAMW{1'b0}}, p_s1.lm} * {{mvcs_pkg::LOGW{1'b0}}, p_s1.gam};
		pprod = pprod + (mvcs_pkg::LOGW+mvcs_pkg::GAMW)'(1 << (F - 1));
		n2.pm = mvcs_pkg::PW'(pprod >> F);
		qprod = {11'd0, p_s1.x} * 26'(mvcs_pkg::BYP_RECIP);
		n2.q0 = 9'(qprod >> mvcs_pkg::BYP_SHIFT);
	end

	// Stage 3: split the signed exponent, finish the bypass division.
	mvcs_pkg::pipe_t n3;
	logic [mvcs_pkg::PW-1:0] pv;
	logic [15:0] rem3;
	logic [8:0]  q3;

	always_comb begin
		n3 = p_s2;
		pv = p_s2.neg ? (~p_s2.pm + mvcs_pkg::PW'(1)) : p_s2.pm;
		n3.ip = $signed(pv[mvcs_pkg::PW-1:F]);
		n3.f = pv[F-1:0];
		n3.y = mvcs_pkg::YW'(1 << F);
		rem3 = {1'b0, p_s2.x} - 16'({7'd0, p_s2.q0} * 16'(mvcs_pkg::BYP_DIV));
		q3 = p_s2.q0 + ((rem3 >= 16'(mvcs_pkg::BYP_DIV)) ? 9'd1 : 9'd0);
		n3.sc_byp = {3'd0, p_s2.lo} + {1'b0, q3};
	end

	mvcs_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_stall  (exp_in_stall),
		.in_data   (p_s3),
		.out_valid (exp_out_valid),
		.out_stall (!rdy4),
		.out_data  (exp_out)
	);

	// Stage 4: apply the integer part of the exponent.
	localparam int IPW_L = mvcs_pkg::IPW;
	mvcs_pkg::pipe_t n4;
	logic [IPW_L-1:0] amt4;

	always_comb begin
		n4 = exp_out;
		amt4 = IPW_L'(-exp_out.ip);
		if (exp_out.mzero) begin
			n4.s = '0;
		end else if (exp_out.ip >= 0) begin
			if (exp_out.ip > IPW_L'(mvcs_pkg::IP_MAX)) begin
				n4.s = mvcs_pkg::SW'(exp_out.y) << mvcs_pkg::IP_MAX;
			end else begin
				n4.s = mvcs_pkg::SW'(exp_out.y) << exp_out.ip;
			end
		end else begin
			n4.s = mvcs_pkg::SW'(exp_out.y) >> amt4;
		end
	end

	// Stage 5: map into the output range and clamp.
	mvcs_pkg::res_t n5;
	logic [mvcs_pkg::PRODW-1:0] sprod;
	logic [mvcs_pkg::SCW-1:0]   scv;

	always_comb begin
		n5 = p_s4.msg;
		sprod = {7'd0, p_s4.s} * {{mvcs_pkg::SW{1'b0}}, p_s4.d};
		sprod = sprod + mvcs_pkg::PRODW'(1 << (F - 1));
		scv = mvcs_pkg::SCW'(sprod >> F) + mvcs_pkg::SCW'(p_s4.lo);
		if (p_s4.note) begin
			n5.out_second = p_s4.byp ?
				mvcs_pkg::clamp_vel(mvcs_pkg::SCW'(p_s4.sc_byp)) : mvcs_pkg::clamp_vel(scv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= msg_valid && (msg.message_length != 2'd0);
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= exp_out_valid;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) p_s1 <= n1;
		if (rdy2) p_s2 <= n2;
		if (rdy3) p_s3 <= n3;
		if (rdy4) p_s4 <= n4;
		if (rdy5) r_s5 <= n5;
	end

	assign res_valid = v_s5;
	assign res = r_s5;

`ifndef SYNTHESIS
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.out_length != 2'd0)
		else $error("result with zero length");

	a_vel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.out_status[7:4] == mvcs_pkg::NOTE_ON &&
		res.out_length == mvcs_pkg::LEN_FULL |-> res.out_second <= 8'd127)
		else $error("note-on velocity out of range");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !msg_stall)
		else $error("request stalled with first stage empty");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !v_s5 |=> v_s5)
		else $error("output stage failed to load");
`endif

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 21;
	localparam int FRAC_BITS = mvcs_pkg::FRAC_BITS;
	localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic msg_valid, msg_stall;
	mvcs_pkg::msg_t msg;
	logic res_valid, res_stall;
	mvcs_pkg::res_t res;

	midi_velocity_curve_scaler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.msg_valid(msg_valid), .msg_stall(msg_stall), .msg(msg),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// Shadow copy of the registers for the predictor.
	logic [6:0] vel_lo_reg, vel_hi_reg;
	logic signed [7:0] curve_reg;

	mvcs_pkg::res_t scaled_q[$];
	int errors;
	int n_sent, n_got, n_notes;
	bit quiet;
	bit hold_long;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint unsigned sq_root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned fx_log2(int unsigned m);
		int unsigned k;
		longint unsigned x, fr;
		k = 0;
		fr = 0;
		while (k < 31 && (m >> (k + 1)) != 0) k++;
		x = (longint'(m) << FRAC_BITS) >> k;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			x = (x * x) >> FRAC_BITS;
			if (x >= 2 * ONE) begin
				x >>= 1;
				fr |= 64'd1 << (FRAC_BITS - i);
			end
		end
		return (longint'(k) << FRAC_BITS) | fr;
	endfunction

	function automatic longint unsigned fx_exp2(longint p);
		longint ip;
		longint unsigned f, r, y, a, im;
		r = 2 * ONE;
		y = ONE;
		if (p >= 0) begin
			ip = p >> FRAC_BITS;
			f = p & (ONE - 1);
		end else begin
			a = -p;
			im = (a + ONE - 1) >> FRAC_BITS;
			ip = -longint'(im);
			f = (im << FRAC_BITS) - a;
		end
		for (int i = 1; i <= FRAC_BITS; i++) begin
			r = sq_root(r << FRAC_BITS);
			if (f[FRAC_BITS - i]) y = (y * r) >> FRAC_BITS;
		end
		if (ip > 8) ip = 8;
		if (ip >= 0) return y << ip;
		if (ip <= -63) return 0;
		return y >> (-ip);
	endfunction

	function automatic mvcs_pkg::res_t scale_velocity(mvcs_pkg::msg_t m);
		mvcs_pkg::res_t r;
		longint unsigned lo, hi, d, mv, sc, s, mag, gam, la, lb, lm, pm;
		longint c, e, p;
		bit neg;
		r.out_status = m.status_byte;
		r.out_length = m.message_length;
		r.out_first = (m.message_length > 1) ? m.first_data : 8'd0;
		r.out_second = (m.message_length > 2) ? m.second_data : 8'd0;
		if (m.status_byte[7:4] == mvcs_pkg::NOTE_ON && m.message_length == mvcs_pkg::LEN_FULL
				&& m.second_data != 0) begin
			lo = vel_lo_reg;
			hi = vel_hi_reg;
			if (lo > hi) begin
				lo = vel_hi_reg;
				hi = vel_lo_reg;
			end
			d = hi - lo;
			mv = m.second_data - 1;
			c = curve_reg;
			if (c < -100) c = -100;
			if (c > 100) c = 100;
			if (c == 0) begin
				sc = lo + (mv * d + 63) / 126;
			end else begin
				s = 0;
				if (mv != 0) begin
					mag = (((c < 0) ? -c : c) * ONE + 25) / 50;
					e = (c > 0) ? -longint'(mag) : longint'(mag);
					gam = fx_exp2(e);
					la = fx_log2(mv);
					lb = fx_log2(126);
					neg = la < lb;
					lm = neg ? lb - la : la - lb;
					pm = (lm * gam + (ONE >> 1)) >> FRAC_BITS;
					p = neg ? -longint'(pm) : longint'(pm);
					s = fx_exp2(p);
				end
				sc = lo + ((s * d + (ONE >> 1)) >> FRAC_BITS);
			end
			if (sc < 1) sc = 1;
			if (sc > 127) sc = 127;
			r.out_second = sc[7:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, n_got);
	endtask

	// Results are compared as they are accepted.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			mvcs_pkg::res_t w;
			if (scaled_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = scaled_q.pop_front();
				if (res.out_status != w.out_status)
					report_mismatch("status", res.out_status, w.out_status);
				if (res.out_first != w.out_first)
					report_mismatch("first", res.out_first, w.out_first);
				if (res.out_second != w.out_second)
					report_mismatch("second", res.out_second, w.out_second);
				if (res.out_length != w.out_length)
					report_mismatch("length", res.out_length, w.out_length);
			end
			n_got++;
		end
	end

	// Receiver stall: random bursts, or one long hold-off when asked.
	initial begin
		int k;
		res_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				res_stall <= 1;
				for (k = 0; k < 80; k++) @(negedge clk);
				hold_long = 0;
				res_stall <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				res_stall <= 1;
				k = $urandom_range(1, 19);
				repeat (k) @(negedge clk);
				res_stall <= 0;
			end
		end
	end

	task automatic apb_write(mvcs_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 4'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			mvcs_pkg::REG_FLOOR: vel_lo_reg = val[6:0];
			mvcs_pkg::REG_CEIL: vel_hi_reg = val[6:0];
			default: curve_reg = val[7:0];
		endcase
	endtask

	task automatic drain();
		while (scaled_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_msg(mvcs_pkg::msg_t m, bit gaps);
		int g;
		if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			msg_valid <= 0;
			g = $urandom_range(1, 19);
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		msg_valid <= 1;
		msg <= m;
		@(posedge clk);
		while (msg_stall) @(posedge clk);
		if (m.message_length != 0) scaled_q.push_back(scale_velocity(m));
		if (m.status_byte[7:4] == mvcs_pkg::NOTE_ON && m.message_length == mvcs_pkg::LEN_FULL)
			n_notes++;
		n_sent++;
	endtask

	task automatic idle_in();
		@(negedge clk);
		msg_valid <= 0;
	endtask

	function automatic mvcs_pkg::msg_t rand_msg();
		mvcs_pkg::msg_t m;
		m.status_byte = $urandom_range(0, 255);
		if ($urandom_range(0, 3) != 0) m.status_byte[7:4] = mvcs_pkg::NOTE_ON;
		m.first_data = $urandom_range(0, 255);
		m.second_data = ($urandom_range(0, 4) == 0) ? $urandom_range(128, 255)
			: $urandom_range(0, 127);
		m.message_length = ($urandom_range(0, 3) != 0) ? mvcs_pkg::LEN_FULL
			: $urandom_range(0, 2);
		return m;
	endfunction

	typedef struct {
		mvcs_pkg::msg_t m;
		bit             known;
		mvcs_pkg::res_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	task automatic add_row(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
			logic [1:0] len, bit known, logic [7:0] w2);
		dir_row_t r;
		r.m = '{st, d1, d2, len};
		r.known = known;
		r.want = '{st, (len > 1) ? d1 : 8'd0, w2, len};
		dir_rows.push_back(r);
	endtask

	initial begin
		logic [6:0] lo_set[4] = '{7'd1, 7'd127, 7'd0, 7'd40};
		logic [6:0] hi_set[4] = '{7'd127, 7'd1, 7'd127, 7'd90};
		logic signed [7:0] cv_set[6] = '{8'sd100, -8'sd100, 8'sd127, -8'sd128, 8'sd37, 8'sd0};
		mvcs_pkg::msg_t m;
		errors = 0;
		n_sent = 0;
		n_got = 0;
		n_notes = 0;
		quiet = 0;
		hold_long = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		msg_valid = 0;
		msg = '0;
		vel_lo_reg = 1;
		vel_hi_reg = 127;
		curve_reg = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset values give the identity map on velocity.
		add_row(8'h90, 8'd60, 8'd1, 2'd3, 1, 8'd1);
		add_row(8'h9F, 8'd0, 8'd127, 2'd3, 1, 8'd127);
		add_row(8'h95, 8'd255, 8'd64, 2'd3, 1, 8'd64);
		add_row(8'h90, 8'd10, 8'd0, 2'd3, 1, 8'd0);
		add_row(8'h93, 8'd10, 8'd50, 2'd2, 1, 8'd0);
		add_row(8'h80, 8'd77, 8'd99, 2'd3, 1, 8'd99);
		add_row(8'hFF, 8'hFF, 8'hFF, 2'd1, 1, 8'd0);
		add_row(8'h00, 8'h00, 8'h00, 2'd3, 1, 8'd0);
		add_row(8'h90, 8'd1, 8'd255, 2'd3, 1, 8'd127);
		add_row(8'h90, 8'd1, 8'd200, 2'd0, 0, 8'd0);
		add_row(8'h9A, 8'd5, 8'd128, 2'd3, 0, 8'd0);
		add_row(8'h90, 8'd5, 8'd2, 2'd3, 0, 8'd0);
		foreach (dir_rows[i]) begin
			send_msg(dir_rows[i].m, 0);
			if (dir_rows[i].known && dir_rows[i].m.message_length != 0)
				scaled_q[scaled_q.size() - 1] = dir_rows[i].want;
		end
		idle_in();
		drain();

		// Curve extremes and out of range codes with a swapped range.
		apb_write(mvcs_pkg::REG_FLOOR, 32'd127);
		apb_write(mvcs_pkg::REG_CEIL, 32'd1);
		for (int c = 0; c < 6; c++) begin
			apb_write(mvcs_pkg::REG_CURVE, 32'(cv_set[c]));
			for (int v = 0; v < 256; v += 37)
				send_msg('{8'h90, 8'd3, 8'(v), mvcs_pkg::LEN_FULL}, 0);
			idle_in();
			drain();
		end

		// Random phases over register settings.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 4) begin
				apb_write(mvcs_pkg::REG_FLOOR, {$urandom} & 32'hFFFF_FF00 | 32'(lo_set[ph]));
				apb_write(mvcs_pkg::REG_CEIL, 32'(hi_set[ph]));
			end else begin
				apb_write(mvcs_pkg::REG_FLOOR, $urandom);
				apb_write(mvcs_pkg::REG_CEIL, $urandom);
			end
			apb_write(mvcs_pkg::REG_CURVE, (ph == 1) ? 32'd0 : $urandom_range(0, 255));
			if (ph == 7) quiet = 1;
			if (ph == 2) hold_long = 1;
			for (int i = 0; i < 55; i++) begin
				m = rand_msg();
				send_msg(m, 1);
			end
			idle_in();
			drain();
		end
		repeat (LATENCY) @(posedge clk);

		$display("sent %0d messages (%0d full note-ons) and checked %0d results",
			n_sent, n_notes, n_got);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
src/mvcs_pkg.sv
src/mvcs_exp2.sv
src/midi_velocity_curve_scaler.sv
dv/tb.sv
